>>> rtl/vrq_pkg.sv
// vrq_pkg: shared constants, codes and the command type of the record ring queue.
// Used by every module of the block; no dependencies.
`default_nettype none

package vrq_pkg;

	localparam int CAPACITY     = 1024;
	localparam int MAX_RECORD   = 64;
	localparam int HEADER_BYTES = 4;
	localparam int FIFO_DEPTH   = 4;

	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int TAIL_W     = IDX_W + 1;
	localparam int POS_W      = 32;
	localparam int HDR_CNT_W  = $clog2(HEADER_BYTES);
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam int OP_W       = 2;
	localparam int LEN_W      = 7;
	localparam int BYTE_W     = 8;
	localparam int ROOM_W     = 8;
	localparam int TOTAL_W    = 8;
	localparam int STATUS_W   = 3;
	localparam int S_TDATA_W  = 24;
	localparam int M_TDATA_W  = 16;

	localparam logic [OP_W-1:0] OP_PUSH_BEGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BYTE  = 2'd1;
	localparam logic [OP_W-1:0] OP_POP        = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

	localparam logic [STATUS_W-1:0] ST_PUSH_OK   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POP_BYTE  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_POP_BIG   = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] data;
		logic [ROOM_W-1:0] room;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/vrq_front.sv
// vrq_front: input stage; decodes stream words into commands and queues them.
// Depends on vrq_pkg.
`default_nettype none

module vrq_front import vrq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // record_length, data_byte, reader_room, pad
	input  wire logic [OP_W-1:0]      s_tuser,  // operation
	output logic                      cmd_valid,
	output cmd_t                      cmd,
	input  wire logic                 cmd_take
);

	cmd_t              fifo_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] cnt_q;
	cmd_t              in_cmd;
	logic              push;
	logic              pop;

	assign s_tready  = (cnt_q != FCNT_W'(FIFO_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];

	assign in_cmd.op   = s_tuser;
	assign in_cmd.len  = s_tdata[LEN_W-1:0];
	assign in_cmd.data = s_tdata[LEN_W+BYTE_W-1:LEN_W];
	assign in_cmd.room = s_tdata[LEN_W+BYTE_W+ROOM_W-1:LEN_W+BYTE_W];

	// drop the unused operation code here
	assign push = s_tvalid && s_tready && (s_tuser != OP_UNUSED);
	assign pop  = cmd_valid && cmd_take;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + FCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - FCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/vrq_back.sv
// vrq_back: executes queued commands against the byte ring store and drives results.
// Depends on vrq_pkg; fed by vrq_front.
`default_nettype none

module vrq_back import vrq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	input  wire cmd_t                 cmd,
	output logic                      cmd_take,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // out_byte, popped_length, pad
	output logic [STATUS_W-1:0]       m_tuser,  // status
	output logic                      m_tlast
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PB_CHK,
		S_PB_ROOM,
		S_MARK,
		S_HDR_WR,
		S_POP_CHK,
		S_HDR_RD,
		S_HDR_ACC,
		S_POP_EVAL,
		S_BYTE_RD,
		S_BYTE_OUT,
		S_EMIT
	} state_t;

	state_t                state_q;
	cmd_t                  cmd_q;
	logic [BYTE_W-1:0]     byte_store_q [CAPACITY];
	logic [BYTE_W-1:0]     rdata_q;
	logic [POS_W-1:0]      wp_q;
	logic [POS_W-1:0]      rp_q;
	logic [POS_W-1:0]      pend_q;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      hdr_q;
	logic [LEN_W-1:0]      exp_q;
	logic [IDX_W-1:0]      fill_q;
	logic [IDX_W-1:0]      line_q;
	logic [IDX_W-1:0]      wr_addr_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic [HDR_CNT_W-1:0]  wk_q;
	logic [HDR_CNT_W-1:0]  hk_q;
	logic [TOTAL_W-1:0]    total_q;
	logic                  marker_q;
	logic [LEN_W-1:0]      cnt_q;
	logic [LEN_W-1:0]      plen_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic [LEN_W-1:0]      res_len_q;
	logic                  m_tvalid_q;
	logic [BYTE_W-1:0]     m_byte_q;
	logic [LEN_W-1:0]      m_len_q;
	logic [STATUS_W-1:0]   m_status_q;
	logic                  m_last_q;

	logic                  out_free;
	logic [POS_W-1:0]      used;
	logic [IDX_W-1:0]      rline;
	logic [TAIL_W-1:0]     rtail;
	logic                  skip_past;
	logic [IDX_W-1:0]      wline;
	logic [TAIL_W-1:0]     wtail;
	logic [TOTAL_W-1:0]    total;
	logic                  bad_len;
	logic                  wrap;
	logic                  byte_last;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [BYTE_W-1:0]     wdata;

	assign out_free  = !m_tvalid_q || m_tready;
	assign used      = wp_q - rp_q;
	assign rline     = rp_q[IDX_W-1:0];
	assign rtail     = TAIL_W'(CAPACITY) - {1'b0, rline};
	assign skip_past = POS_W'(rtail) > used;
	assign wline     = wp_q[IDX_W-1:0];
	assign wtail     = TAIL_W'(CAPACITY) - {1'b0, wline};
	assign total     = TOTAL_W'(HEADER_BYTES) + {1'b0, cmd_q.len};
	assign bad_len   = (cmd_q.len == '0) || (cmd_q.len > LEN_W'(MAX_RECORD))
		|| (POS_W'(total) >= POS_W'(CAPACITY));
	assign wrap      = POS_W'(wtail) < POS_W'(total);
	assign byte_last = (cnt_q + LEN_W'(1)) == plen_q;

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;

	always_comb begin
		we    = 1'b0;
		waddr = wr_addr_q;
		wdata = '0;
		case (state_q)
			S_IDLE: begin
				we    = cmd_valid && (cmd.op == OP_PUSH_BYTE) && (exp_q != '0);
				waddr = fill_q;
				wdata = cmd.data;
			end
			S_MARK: begin
				we = 1'b1;
			end
			S_HDR_WR: begin
				we    = 1'b1;
				wdata = (wk_q == '0) ? BYTE_W'(cmd_q.len) : '0;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			byte_store_q[waddr] <= wdata;
		end
		rdata_q <= byte_store_q[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			wp_q         <= '0;
			rp_q         <= '0;
			pend_q       <= '0;
			pos_q        <= '0;
			hdr_q        <= '0;
			exp_q        <= '0;
			fill_q       <= '0;
			line_q       <= '0;
			wr_addr_q    <= '0;
			rd_addr_q    <= '0;
			wk_q         <= '0;
			hk_q         <= '0;
			total_q      <= '0;
			marker_q     <= 1'b0;
			cnt_q        <= '0;
			plen_q       <= '0;
			res_status_q <= ST_PUSH_OK;
			res_len_q    <= '0;
			m_tvalid_q   <= 1'b0;
			m_byte_q     <= '0;
			m_len_q      <= '0;
			m_status_q   <= ST_PUSH_OK;
			m_last_q     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_BYTE_OUT) && (state_q != S_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.op)
							OP_PUSH_BEGIN: begin
								state_q <= S_PB_CHK;
							end
							OP_PUSH_BYTE: begin
								if (exp_q != '0) begin
									fill_q <= fill_q + IDX_W'(1);
									exp_q  <= exp_q - LEN_W'(1);
									if (exp_q == LEN_W'(1)) begin
										wp_q <= pend_q;
									end
								end
							end
							OP_POP: begin
								state_q <= S_POP_CHK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_PB_CHK: begin
					exp_q <= '0;
					if (bad_len) begin
						res_status_q <= ST_PUSH_FULL;
						res_len_q    <= '0;
						state_q      <= S_EMIT;
					end else begin
						pos_q    <= wrap ? (wp_q + POS_W'(wtail)) : wp_q;
						line_q   <= wrap ? '0 : wline;
						marker_q <= wrap && (wtail >= TAIL_W'(HEADER_BYTES));
						total_q  <= total;
						state_q  <= S_PB_ROOM;
					end
				end
				S_PB_ROOM: begin
					wk_q <= '0;
					if ((pos_q - rp_q) >= (POS_W'(CAPACITY) - POS_W'(total_q))) begin
						res_status_q <= ST_PUSH_FULL;
						res_len_q    <= '0;
						state_q      <= S_EMIT;
					end else if (marker_q) begin
						wr_addr_q <= wline;
						state_q   <= S_MARK;
					end else begin
						wr_addr_q <= line_q;
						state_q   <= S_HDR_WR;
					end
				end
				S_MARK: begin
					wk_q <= wk_q + HDR_CNT_W'(1);
					if (wk_q == HDR_CNT_W'(HEADER_BYTES - 1)) begin
						wr_addr_q <= line_q;
						state_q   <= S_HDR_WR;
					end else begin
						wr_addr_q <= wr_addr_q + IDX_W'(1);
					end
				end
				S_HDR_WR: begin
					wk_q      <= wk_q + HDR_CNT_W'(1);
					wr_addr_q <= wr_addr_q + IDX_W'(1);
					if (wk_q == HDR_CNT_W'(HEADER_BYTES - 1)) begin
						fill_q       <= line_q + IDX_W'(HEADER_BYTES);
						exp_q        <= cmd_q.len;
						pend_q       <= pos_q + POS_W'(total_q);
						res_status_q <= ST_PUSH_OK;
						res_len_q    <= '0;
						state_q      <= S_EMIT;
					end
				end
				S_POP_CHK: begin
					if (used < POS_W'(HEADER_BYTES)) begin
						res_status_q <= ST_POP_EMPTY;
						res_len_q    <= '0;
						state_q      <= S_EMIT;
					end else if (rtail < TAIL_W'(HEADER_BYTES)) begin
						if (skip_past) begin
							rp_q         <= wp_q;
							res_status_q <= ST_POP_EMPTY;
							res_len_q    <= '0;
							state_q      <= S_EMIT;
						end else begin
							rp_q <= rp_q + POS_W'(rtail);
						end
					end else begin
						rd_addr_q <= rline;
						hk_q      <= '0;
						state_q   <= S_HDR_RD;
					end
				end
				S_HDR_RD: begin
					state_q <= S_HDR_ACC;
				end
				S_HDR_ACC: begin
					hdr_q     <= {rdata_q, hdr_q[POS_W-1:BYTE_W]};
					rd_addr_q <= rd_addr_q + IDX_W'(1);
					hk_q      <= hk_q + HDR_CNT_W'(1);
					state_q   <= (hk_q == HDR_CNT_W'(HEADER_BYTES - 1)) ? S_POP_EVAL : S_HDR_RD;
				end
				S_POP_EVAL: begin
					if (hdr_q == '0) begin
						if (skip_past) begin
							rp_q         <= wp_q;
							res_status_q <= ST_POP_EMPTY;
							res_len_q    <= '0;
							state_q      <= S_EMIT;
						end else begin
							rp_q    <= rp_q + POS_W'(rtail);
							state_q <= S_POP_CHK;
						end
					end else if (hdr_q > (used - POS_W'(HEADER_BYTES))) begin
						res_status_q <= ST_POP_EMPTY;
						res_len_q    <= '0;
						state_q      <= S_EMIT;
					end else if ((hdr_q > POS_W'(cmd_q.room)) || (hdr_q > POS_W'(MAX_RECORD))) begin
						res_status_q <= ST_POP_BIG;
						res_len_q    <= hdr_q[LEN_W-1:0];
						state_q      <= S_EMIT;
					end else begin
						cnt_q   <= '0;
						plen_q  <= hdr_q[LEN_W-1:0];
						state_q <= S_BYTE_RD;
					end
				end
				S_BYTE_RD: begin
					state_q <= S_BYTE_OUT;
				end
				S_BYTE_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= ST_POP_BYTE;
						m_byte_q   <= rdata_q;
						m_last_q   <= byte_last;
						m_len_q    <= plen_q;
						rd_addr_q  <= rd_addr_q + IDX_W'(1);
						cnt_q      <= cnt_q + LEN_W'(1);
						if (byte_last) begin
							rp_q    <= rp_q + POS_W'(HEADER_BYTES) + POS_W'(plen_q);
							state_q <= S_IDLE;
						end else begin
							state_q <= S_BYTE_RD;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_status_q <= res_status_q;
						m_byte_q   <= '0;
						m_last_q   <= 1'b0;
						m_len_q    <= res_len_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {{(M_TDATA_W - BYTE_W - LEN_W){1'b0}}, m_len_q, m_byte_q};

endmodule

`default_nettype wire

>>> rtl/variable_record_ring_queue.sv
// variable_record_ring_queue: top level of the length-prefixed byte ring queue.
// Instantiates vrq_front and vrq_back; depends on vrq_pkg.
//
//   channel | tdata                                     | tuser         | tlast
//   s_*     | [6:0] record_length [14:7] data_byte       | [1:0] op      | -
//           | [22:15] reader_room                        |               |
//   m_*     | [7:0] out_byte [14:8] popped_length        | [2:0] status  | last byte
//
// Push data byte writes the store straight from idle. Push begin checks length and room, writes
// a wrap marker if one is needed, then the header. Pop checks the fill, reads the header byte
// by byte, then emits the record bytes or one empty or too-big word; a short tail or marker skips.
// All store traffic goes through one write and one registered read port of the byte store.
// Reset clears positions and counters at once; the store needs no clearing pass.
// A four-entry command queue takes input words while results wait on m_tready.
`default_nettype none

module variable_record_ring_queue import vrq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // record_length, data_byte, reader_room, pad
	input  wire logic [OP_W-1:0]      s_tuser,  // operation
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // out_byte, popped_length, pad
	output logic [STATUS_W-1:0]       m_tuser,  // status
	output logic                      m_tlast
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;

	vrq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	vrq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

>>> rtl/vrq_checker.sv
// vrq_checker: port-level checks on the result stream of the ring queue.
// Depends on vrq_pkg; bound to variable_record_ring_queue.
`default_nettype none

module vrq_checker import vrq_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [STATUS_W-1:0]  m_tuser,
	input wire logic                 m_tlast
);

	logic is_byte;

	assign is_byte = (m_tuser == ST_POP_BYTE);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_last_only_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !is_byte |-> !m_tlast && (m_tdata[BYTE_W-1:0] == '0))
		else $error("byte or last flag on a non-byte result");

	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !is_byte && (m_tuser != ST_POP_BIG)
			|-> (m_tdata[BYTE_W+LEN_W-1:BYTE_W] == '0))
		else $error("length on a result that carries none");

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && is_byte |-> (m_tdata[BYTE_W+LEN_W-1:BYTE_W] != '0)
			&& (m_tdata[BYTE_W+LEN_W-1:BYTE_W] <= LEN_W'(MAX_RECORD)))
		else $error("popped byte with impossible record length");

endmodule

bind variable_record_ring_queue vrq_checker u_vrq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
